// ----- rtl/pip_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pip_pkg;
    localparam int MAX_VERTICES = 1024;
    localparam int CNT_W = 11;
    localparam int TOL_W = 31;
    localparam int CFG_W = 31;
    localparam int IDX_W = 10;
    localparam logic [0:0] CFG_VERTEX_COUNT   = 1'b0;
    localparam logic [0:0] CFG_NEAR_TOLERANCE = 1'b1;
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [IDX_W-1:0]   vertex_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic             inside_res;
        logic             by_proximity;
        logic [IDX_W-1:0] nearest_index;
    } t_out_item;

    // shared signed multiplier operands (33x33)
    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
    } t_mul_req;
endpackage
`default_nettype wire

// ----- rtl/pip_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pip_mul (
    input  wire logic               i_clk,
    input  wire pip_pkg::t_mul_req  i_req,
    output logic signed [65:0]      o_prod
);
    import pip_pkg::*;
    logic signed [65:0] r_prod;
    always_ff @(posedge i_clk) begin
        r_prod <= 66'(i_req.a) * 66'(i_req.b);
    end
    assign o_prod = r_prod;
endmodule
`default_nettype wire

// ----- rtl/point_in_polygon_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Point-in-polygon tester over a vertex table of up to P_MAX_VERTICES signed Q16.16
// points. A write beat stores one vertex and its all-zero result is registered at
// the accepting edge. A query beat walks the table with one shared 33x33
// multiplier, one vertex read per step, over n = clamped vertex_count vertices:
// a bounding-box pass, a setup step that checks the box and latches vertex n-1, an
// even-odd crossing pass over each edge, a decision step, and when the point is
// outside the bounding box or not inside by crossing, a nearest-vertex pass over
// each vertex plus a step for the tolerance square. A point outside the box skips
// the crossing pass. The block takes no input while a query runs or a result waits,
// so the next beat is taken the cycle after the result is taken. Unwritten vertex
// slots read as undefined.
module point_in_polygon_test #(
    parameter int P_MAX_VERTICES = pip_pkg::MAX_VERTICES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire pip_pkg::t_in_item          i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output pip_pkg::t_out_item              o_out_data,
    input  wire logic                       i_cfg_we,
    input  wire logic [0:0]                 i_cfg_index,
    input  wire logic [pip_pkg::CFG_W-1:0]  i_cfg_data
);
    import pip_pkg::*;
    localparam int AW = (P_MAX_VERTICES > 1) ? $clog2(P_MAX_VERTICES) : 1;
    localparam int NW = $clog2(P_MAX_VERTICES + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_BB = 4'd1, S_BB2 = 4'd2, S_CRD = 4'd3,
                           S_CRC = 4'd4, S_CRA = 4'd5, S_CRB = 4'd6, S_CRE = 4'd7,
                           S_OUT = 4'd8, S_NRD = 4'd9, S_NRA = 4'd10, S_NRB = 4'd11,
                           S_NRC = 4'd12, S_TOL = 4'd13, S_FIN = 4'd14;

    logic [3:0] r_st;
    logic [CNT_W-1:0] r_vcnt;
    logic [TOL_W-1:0] r_tol;
    logic [NW-1:0] r_n, r_i, r_rd;
    logic signed [31:0] r_px, r_py;

    logic signed [31:0] r_memx [P_MAX_VERTICES];
    logic signed [31:0] r_memy [P_MAX_VERTICES];
    logic signed [31:0] r_rx, r_ry;

    logic signed [31:0] r_minx, r_maxx, r_miny, r_maxy;
    logic signed [31:0] r_xj, r_yj, r_xi, r_yi;
    logic r_first, r_c, r_neg, r_ov;
    logic signed [65:0] r_lhs;
    logic [65:0] r_best, r_d;
    logic [IDX_W-1:0] r_near;
    t_out_item r_out;

    t_mul_req mul_req;
    logic signed [65:0] mul_p;
    pip_mul u_mul (.i_clk(i_clk), .i_req(mul_req), .o_prod(mul_p));

    logic in_acc;
    assign o_in_stall = (r_st != S_IDLE) || r_ov;
    assign in_acc = i_in_valid && !o_in_stall;

    // clamp vertex count
    logic [NW-1:0] nclamp;
    always_comb begin
        if (r_vcnt == '0) nclamp = NW'(1);
        else if (32'(r_vcnt) > P_MAX_VERTICES) nclamp = NW'(P_MAX_VERTICES);
        else nclamp = NW'(r_vcnt);
    end

    // memory: one write, one registered read
    logic [AW-1:0] rd_addr;
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.operation == OP_WRITE &&
            32'(i_in_data.vertex_index) < P_MAX_VERTICES) begin
            r_memx[AW'(i_in_data.vertex_index)] <= i_in_data.point_x;
            r_memy[AW'(i_in_data.vertex_index)] <= i_in_data.point_y;
        end
        r_rx <= r_memx[rd_addr];
        r_ry <= r_memy[rd_addr];
    end
    assign rd_addr = AW'(r_rd);

    // crossing conditions on the fetched vertex i (with previous j)
    logic gi, gj, straddle;
    logic signed [32:0] span;
    assign gi = r_ry > r_py;
    assign gj = r_yj > r_py;
    assign straddle = gi != gj;
    assign span = 33'(r_yj) - 33'(r_ry);

    // squared distance: dx^2 held in r_d, dy^2 on the multiplier output
    logic [65:0] dsq;
    assign dsq = r_d + $unsigned(mul_p);

    always_comb begin
        mul_req.a = '0;
        mul_req.b = '0;
        unique case (r_st)
            S_CRA: begin
                mul_req.a = 33'(r_px) - 33'(r_rx);
                mul_req.b = span;
            end
            S_CRB: begin
                mul_req.a = 33'(r_xj) - 33'(r_xi);
                mul_req.b = 33'(r_py) - 33'(r_yi);
            end
            S_NRA: begin
                mul_req.a = 33'(r_px) - 33'(r_rx);
                mul_req.b = 33'(r_px) - 33'(r_rx);
            end
            S_NRB: begin
                mul_req.a = 33'(r_py) - 33'(r_yi);
                mul_req.b = 33'(r_py) - 33'(r_yi);
            end
            S_TOL: begin
                mul_req.a = 33'(r_tol);
                mul_req.b = 33'(r_tol);
            end
            default: ;
        endcase
    end

    logic [NW-1:0] last_i;
    assign last_i = r_n - NW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_vcnt <= CNT_W'(4);
            r_tol <= TOL_W'(32768);
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VERTEX_COUNT:   r_vcnt <= i_cfg_data[CNT_W-1:0];
                    CFG_NEAR_TOLERANCE: r_tol <= i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end
            if (r_ov && !i_out_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (in_acc) begin
                    if (i_in_data.operation == OP_QUERY) begin
                        r_px <= i_in_data.point_x;
                        r_py <= i_in_data.point_y;
                        r_n <= nclamp;
                        r_rd <= '0;
                        r_i <= '0;
                        r_first <= 1'b1;
                        r_c <= 1'b0;
                        r_near <= '0;
                        r_st <= S_BB;
                    end else begin
                        r_out <= '0;
                        r_ov <= 1'b1;
                    end
                end
                S_BB: begin
                    // read issued for r_rd; data appears next cycle
                    r_rd <= r_rd + NW'(1);
                    r_st <= S_BB2;
                end
                S_BB2: begin
                    if (r_first || r_rx > r_maxx) r_maxx <= r_rx;
                    if (r_first || r_rx < r_minx) r_minx <= r_rx;
                    if (r_first || r_ry > r_maxy) r_maxy <= r_ry;
                    if (r_first || r_ry < r_miny) r_miny <= r_ry;
                    if (r_i == last_i) begin
                        r_rd <= last_i;
                        r_i <= '0;
                        r_st <= S_CRD;
                        r_first <= 1'b1;
                    end else begin
                        r_first <= 1'b0;
                        r_i <= r_i + NW'(1);
                        r_rd <= r_rd + NW'(1);
                    end
                end
                S_CRD: begin
                    // wait for read of r_rd
                    if (r_first) begin
                        if (r_px < r_minx || r_px > r_maxx ||
                            r_py < r_miny || r_py > r_maxy) begin
                            r_rd <= '0;
                            r_i <= '0;
                            r_st <= S_NRD;
                        end else begin
                            r_rd <= '0;
                            r_st <= S_CRC;
                        end
                    end else begin
                        r_st <= S_CRA;
                    end
                end
                S_CRC: begin
                    // r_rx/r_ry hold vertex n-1 = j
                    r_xj <= r_rx;
                    r_yj <= r_ry;
                    r_first <= 1'b0;
                    r_st <= S_CRD;
                end
                S_CRA: begin
                    r_xi <= r_rx;
                    r_yi <= r_ry;
                    r_first <= straddle;
                    r_neg <= span[32];
                    r_st <= S_CRB;
                end
                S_CRB: begin
                    r_lhs <= mul_p;
                    r_st <= S_CRE;
                end
                S_CRE: begin
                    // mul_p = rhs; compare direction follows the span sign
                    if (r_first) begin
                        if (r_neg ? (mul_p < r_lhs) : (r_lhs < mul_p)) r_c <= ~r_c;
                    end
                    r_xj <= r_xi;
                    r_yj <= r_yi;
                    if (r_i == last_i) begin
                        r_first <= 1'b1;
                        r_rd <= '0;
                        r_i <= '0;
                        r_st <= S_OUT;
                    end else begin
                        r_i <= r_i + NW'(1);
                        r_rd <= r_i + NW'(1);
                        r_first <= 1'b0;
                        r_st <= S_CRD;
                    end
                end
                S_OUT: begin
                    if (r_c) begin
                        r_out.inside_res <= 1'b1;
                        r_out.by_proximity <= 1'b0;
                        r_out.nearest_index <= '0;
                        r_ov <= 1'b1;
                        r_st <= S_IDLE;
                    end else begin
                        r_st <= S_NRD;
                    end
                end
                S_NRD: r_st <= S_NRA;
                S_NRA: begin
                    r_yi <= r_ry;
                    r_st <= S_NRB;
                end
                S_NRB: begin
                    r_d <= mul_p;
                    r_st <= S_NRC;
                end
                S_NRC: begin
                    if (r_first || (dsq < r_best)) begin
                        r_best <= dsq;
                        r_near <= IDX_W'(r_i);
                    end
                    r_first <= 1'b0;
                    if (r_i == last_i) begin
                        r_st <= S_TOL;
                    end else begin
                        r_i <= r_i + NW'(1);
                        r_rd <= r_i + NW'(1);
                        r_st <= S_NRD;
                    end
                end
                S_TOL: r_st <= S_FIN;
                S_FIN: begin
                    // mul_p = tolerance squared
                    r_out.inside_res <= r_best < $unsigned(mul_p);
                    r_out.by_proximity <= r_best < $unsigned(mul_p);
                    r_out.nearest_index <= r_near;
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data = r_out;
endmodule
`default_nettype wire
